// File: rtl/core/timed_event_scheduler_assert.svh
// Assertion macros used by the scheduler checker.
`ifndef TIMED_EVENT_SCHEDULER_ASSERT_SVH
`define TIMED_EVENT_SCHEDULER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define TES_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scheduler assertion failed");

// Condition in one cycle implies another condition in the next cycle.
`define TES_ASSERT_NEXT(lbl, cond, nxt) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error("scheduler assertion failed");

`endif

// File: rtl/core/tes_pkg.sv
// Shared types for the timed event scheduler.
package tes_pkg;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_ARM     = 2'd1,
    CMD_CANCEL  = 2'd2,
    CMD_ADVANCE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_QFIRE = 2'd1,
    KIND_SFIRE = 2'd2,
    KIND_FULL  = 2'd3
  } kind_e;

  // One classified request as it travels from the front to the engine.
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] cycles;
    logic [7:0]  tag;
    logic [2:0]  slot;
  } req_t;

endpackage

// File: rtl/core/tes_front.sv
// Request front end: accepts and classifies requests into a two-entry queue.
module tes_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  logic [1:0]    cmd_i,
  input  logic [31:0]   cycles_i,
  input  logic [7:0]    event_tag_i,
  input  logic [2:0]    slot_id_i,
  output logic          fe_valid_o,
  output tes_pkg::req_t fe_req_o,
  input  logic          fe_pop_i
);

  tes_pkg::req_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;
  logic          push;
  tes_pkg::req_t req_in;

  // Classify the raw command code.
  always_comb begin
    req_in.cycles = cycles_i;
    req_in.tag    = event_tag_i;
    req_in.slot   = slot_id_i;
    case (cmd_i)
      tes_pkg::CMD_ADD:    req_in.cmd = tes_pkg::CMD_ADD;
      tes_pkg::CMD_ARM:    req_in.cmd = tes_pkg::CMD_ARM;
      tes_pkg::CMD_CANCEL: req_in.cmd = tes_pkg::CMD_CANCEL;
      default:             req_in.cmd = tes_pkg::CMD_ADVANCE;
    endcase
  end

  assign req_stall_o = (cnt_q == 2'd2);
  assign push        = req_valid_i && !req_stall_o;
  assign fe_valid_o  = (cnt_q != 2'd0);
  assign fe_req_o    = mem_q[rptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= req_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (fe_pop_i) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(fe_pop_i);
    end
  end

endmodule

// File: rtl/core/tes_engine.sv
// Scheduler engine: time counter, sorted event queue, named slots, results.
module tes_engine #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NAMED_SLOTS = 8,
  parameter int TIME_BITS   = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fe_valid_i,
  input  tes_pkg::req_t        fe_req_i,
  output logic                 fe_pop_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_stall_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           fired_tag_o,
  output logic [2:0]           fired_slot_o,
  output logic                 next_valid_o,
  output logic [TIME_BITS-1:0] cycles_to_next_o,
  output logic                 time_overflow_o,
  output logic                 last_o
);

  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW   = (NAMED_SLOTS > 1) ? $clog2(NAMED_SLOTS) : 1;
  localparam int SCW  = $clog2(NAMED_SLOTS + 1);
  localparam int SIDW = (SW > 3) ? SW : 3;
  localparam int SUMW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SCAN, ST_EMIT, ST_DECIDE
  } state_e;

  state_e               state_q;
  tes_pkg::req_t        req_q;
  logic [SUMW-1:0]      sum_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 ovf_q;
  logic [CNTW-1:0]      qcnt_q;
  logic [TIME_BITS-1:0] qdl_q [QUEUE_DEPTH];
  logic [7:0]           qtag_q [QUEUE_DEPTH];
  logic [NAMED_SLOTS-1:0] armed_q;
  logic [TIME_BITS-1:0] sdl_q [NAMED_SLOTS];
  logic [SCW-1:0]       scan_q;
  logic                 bfound_q;
  logic [TIME_BITS-1:0] bdl_q;
  logic [SW-1:0]        bidx_q;
  tes_pkg::kind_e       rkind_q;
  logic [7:0]           rtag_q;
  logic [2:0]           rslot_q;
  logic                 rlast_q;
  logic                 ov_q;
  tes_pkg::kind_e       okind_q;
  logic [7:0]           otag_q;
  logic [2:0]           oslot_q;
  logic                 onv_q;
  logic [TIME_BITS-1:0] onext_q;
  logic                 oovf_q;
  logic                 olast_q;

  logic [TIME_BITS-1:0] due;
  logic                 sum_sat;
  logic [QUEUE_DEPTH-1:0] gt;
  logic                 do_ins, do_pop, do_sfire, qpick, out_free;
  logic [TIME_BITS-1:0] ins_dl [QUEUE_DEPTH];
  logic [7:0]           ins_tag [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] earliest, next_cyc;
  logic                 next_valid;
  logic [SIDW-1:0]      sid_ext;
  logic                 sid_ok;
  logic [SW-1:0]        sid_idx, scan_idx;

  assign sum_sat  = (sum_q > SUMW'(TMAX));
  assign due      = sum_sat ? TMAX : sum_q[TIME_BITS-1:0];
  assign sid_ext  = SIDW'(req_q.slot);
  assign sid_ok   = ((SIDW+1)'(sid_ext) < (SIDW+1)'(NAMED_SLOTS));
  assign sid_idx  = sid_ext[SW-1:0];
  assign scan_idx = scan_q[SW-1:0];
  assign out_free = !ov_q || !rsp_stall_i;
  assign fe_pop_o = (state_q == ST_IDLE) && fe_valid_i;

  // Queue head competes with the best slot; a queued event wins ties.
  assign qpick    = (qcnt_q != '0) && (!bfound_q || qdl_q[0] <= bdl_q);
  assign do_pop   = (state_q == ST_DECIDE) && qpick && (qdl_q[0] <= now_q);
  assign do_sfire = (state_q == ST_DECIDE) && !qpick && bfound_q && (bdl_q <= now_q);
  assign do_ins   = (state_q == ST_EXEC) && (req_q.cmd == tes_pkg::CMD_ADD) &&
                    (qcnt_q != CNTW'(QUEUE_DEPTH));

  // Sorted insertion: entries later than the new deadline move up by one.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gt[i] = (CNTW'(i) < qcnt_q) && (qdl_q[i] > due);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        ins_dl[i]  = qdl_q[(i > 0) ? i - 1 : 0];
        ins_tag[i] = qtag_q[(i > 0) ? i - 1 : 0];
      end else if (gt[i] || CNTW'(i) == qcnt_q) begin
        ins_dl[i]  = due;
        ins_tag[i] = req_q.tag;
      end else begin
        ins_dl[i]  = qdl_q[i];
        ins_tag[i] = qtag_q[i];
      end
    end
  end

  // Cycles until the earliest pending event.
  always_comb begin
    earliest = bdl_q;
    if (qcnt_q != '0) begin
      earliest = qdl_q[0];
      if (bfound_q && bdl_q < qdl_q[0]) earliest = bdl_q;
    end
    next_valid = (qcnt_q != '0) || bfound_q;
    next_cyc   = (next_valid && earliest > now_q) ? earliest - now_q : '0;
  end

  // Queue storage: insert on add, shift down on firing the head.
  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        qdl_q[i]  <= ins_dl[i];
        qtag_q[i] <= ins_tag[i];
      end
    end else if (do_pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        qdl_q[i]  <= qdl_q[i+1];
        qtag_q[i] <= qtag_q[i+1];
      end
    end
  end

  // Control sequencer, scheduler state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      req_q    <= '0;
      sum_q    <= '0;
      now_q    <= '0;
      ovf_q    <= 1'b0;
      qcnt_q   <= '0;
      armed_q  <= '0;
      for (int i = 0; i < NAMED_SLOTS; i++) sdl_q[i] <= '0;
      scan_q   <= '0;
      bfound_q <= 1'b0;
      bdl_q    <= '0;
      bidx_q   <= '0;
      rkind_q  <= tes_pkg::KIND_DONE;
      rtag_q   <= '0;
      rslot_q  <= '0;
      rlast_q  <= 1'b0;
      ov_q     <= 1'b0;
      okind_q  <= tes_pkg::KIND_DONE;
      otag_q   <= '0;
      oslot_q  <= '0;
      onv_q    <= 1'b0;
      onext_q  <= '0;
      oovf_q   <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      // The result register empties when taken; the emit state reloads it instead.
      if (ov_q && !rsp_stall_i && state_q != ST_EMIT) ov_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (fe_valid_i) begin
            req_q   <= fe_req_i;
            sum_q   <= SUMW'(now_q) + SUMW'(fe_req_i.cycles);
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          rkind_q <= (req_q.cmd == tes_pkg::CMD_ADD && !do_ins) ? tes_pkg::KIND_FULL
                                                                : tes_pkg::KIND_DONE;
          rtag_q  <= '0;
          rslot_q <= '0;
          rlast_q <= (req_q.cmd != tes_pkg::CMD_ADVANCE);
          case (req_q.cmd)
            tes_pkg::CMD_ADD: begin
              if (do_ins) qcnt_q <= qcnt_q + CNTW'(1);
            end
            tes_pkg::CMD_ARM: begin
              if (sid_ok) begin
                armed_q[sid_idx] <= 1'b1;
                sdl_q[sid_idx]   <= due;
              end
            end
            tes_pkg::CMD_CANCEL: begin
              if (sid_ok) begin
                armed_q[sid_idx] <= 1'b0;
                sdl_q[sid_idx]   <= '0;
              end
            end
            default: begin
              now_q <= due;
              if (sum_sat) ovf_q <= 1'b1;
            end
          endcase
          scan_q   <= '0;
          bfound_q <= 1'b0;
          state_q  <= ST_SCAN;
        end
        ST_SCAN: begin
          // One named slot per cycle; lowest index wins ties.
          if (armed_q[scan_idx] && (!bfound_q || sdl_q[scan_idx] < bdl_q)) begin
            bfound_q <= 1'b1;
            bdl_q    <= sdl_q[scan_idx];
            bidx_q   <= scan_idx;
          end
          scan_q <= scan_q + SCW'(1);
          if (scan_q == SCW'(NAMED_SLOTS - 1)) begin
            state_q <= (req_q.cmd == tes_pkg::CMD_ADVANCE && !rlast_q &&
                        rkind_q == tes_pkg::KIND_DONE) ? ST_DECIDE : ST_EMIT;
          end
        end
        ST_DECIDE: begin
          scan_q  <= '0;
          rtag_q  <= do_pop ? qtag_q[0] : '0;
          rslot_q <= do_sfire ? 3'(bidx_q) : '0;
          if (do_pop) begin
            bfound_q <= 1'b0;
            qcnt_q   <= qcnt_q - CNTW'(1);
            rkind_q  <= tes_pkg::KIND_QFIRE;
            rlast_q  <= 1'b0;
            state_q  <= ST_SCAN;
          end else if (do_sfire) begin
            bfound_q        <= 1'b0;
            armed_q[bidx_q] <= 1'b0;
            rkind_q         <= tes_pkg::KIND_SFIRE;
            rlast_q         <= 1'b0;
            state_q         <= ST_SCAN;
          end else begin
            // Nothing more is due: closing result, scan result kept.
            rkind_q  <= tes_pkg::KIND_DONE;
            rlast_q  <= 1'b1;
            state_q  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            okind_q <= rkind_q;
            otag_q  <= rtag_q;
            oslot_q <= rslot_q;
            onv_q   <= next_valid;
            onext_q <= next_cyc;
            oovf_q  <= ovf_q;
            olast_q <= rlast_q;
            if (rlast_q) begin
              state_q <= ST_IDLE;
            end else begin
              rkind_q <= tes_pkg::KIND_DONE;
              state_q <= ST_DECIDE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_valid_o      = ov_q;
  assign kind_o           = okind_q;
  assign fired_tag_o      = otag_q;
  assign fired_slot_o     = oslot_q;
  assign next_valid_o     = onv_q;
  assign cycles_to_next_o = onext_q;
  assign time_overflow_o  = oovf_q;
  assign last_o           = olast_q;

endmodule

// File: rtl/core/timed_event_scheduler.sv
// Top level of the timed event scheduler.
// Requests enter on req_valid_i / req_stall_o with cmd_i, cycles_i,
// event_tag_i and slot_id_i; a two-entry queue holds them until the engine
// is free. Results leave on rsp_valid_o / rsp_stall_i, one request giving
// one result (add, arm, cancel) or one result per fired event plus a closing
// result with last_o set (advance).
// An add, arm or cancel goes from acceptance to its result in these steps:
// take the request, execute it, rescan every named slot for the next
// deadline and load the result register. The engine takes no new request
// until it has given the final result for the last one. An advance takes the
// same steps with a decision after the rescan; each fired event adds a
// rescan, a result and a further decision.
// Reset clears time, queue fill, armed slots and the overflow flag.
// While the receiver stalls, the result register holds its result and the
// engine waits; the input queue keeps taking up to two requests.
module timed_event_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NAMED_SLOTS = 8,
  parameter int TIME_BITS   = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [31:0]          cycles_i,
  input  logic [7:0]           event_tag_i,
  input  logic [2:0]           slot_id_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_stall_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           fired_tag_o,
  output logic [2:0]           fired_slot_o,
  output logic                 next_valid_o,
  output logic [TIME_BITS-1:0] cycles_to_next_o,
  output logic                 time_overflow_o,
  output logic                 last_o
);

  logic          fe_valid, fe_pop;
  tes_pkg::req_t fe_req;

  // Front end queue.
  tes_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o,
    .cmd_i, .cycles_i, .event_tag_i, .slot_id_i,
    .fe_valid_o (fe_valid),
    .fe_req_o   (fe_req),
    .fe_pop_i   (fe_pop)
  );

  // Scheduling engine.
  tes_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NAMED_SLOTS (NAMED_SLOTS),
    .TIME_BITS   (TIME_BITS)
  ) u_engine (
    .clk_i, .rst_ni,
    .fe_valid_i (fe_valid),
    .fe_req_i   (fe_req),
    .fe_pop_o   (fe_pop),
    .rsp_valid_o, .rsp_stall_i, .kind_o, .fired_tag_o, .fired_slot_o,
    .next_valid_o, .cycles_to_next_o, .time_overflow_o, .last_o
  );

endmodule

// File: rtl/core/tes_checker.sv
// Port-level checker for the timed event scheduler, bound to the top level.
`include "timed_event_scheduler_assert.svh"

module tes_checker #(
  parameter int TIME_BITS = 48
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 rsp_valid_i,
  input logic                 rsp_stall_i,
  input logic [1:0]           kind_i,
  input logic                 next_valid_i,
  input logic [TIME_BITS-1:0] cycles_to_next_i,
  input logic                 last_i
);

  logic is_fire;

  // A result that reports a fired event of either sort.
  assign is_fire = (kind_i == tes_pkg::KIND_QFIRE) || (kind_i == tes_pkg::KIND_SFIRE);

  `TES_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && rsp_stall_i, rsp_valid_i)
  `TES_ASSERT(a_full_last, rsp_valid_i && kind_i == tes_pkg::KIND_FULL |-> last_i)
  `TES_ASSERT(a_fire_not_last, rsp_valid_i && is_fire |-> !last_i)
  `TES_ASSERT(a_idle_next, rsp_valid_i && !next_valid_i |-> cycles_to_next_i == '0)

endmodule

bind timed_event_scheduler tes_checker #(.TIME_BITS(TIME_BITS)) u_tes_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_valid_o),
  .rsp_stall_i      (rsp_stall_i),
  .kind_i           (kind_o),
  .next_valid_i     (next_valid_o),
  .cycles_to_next_i (cycles_to_next_o),
  .last_i           (last_o)
);
